// ----- rtl/i2cbm_pkg.sv -----
// i2cbm_pkg: shared types and codes for the i2c bit master
// input and result word structs, command codes, configuration register indexes
// no dependencies
package i2cbm_pkg;

  localparam int BYTE_BITS = 8;
  localparam int QUEUE_DEPTH = 2;

  // kind codes of the input word
  localparam logic [2:0] KIND_TICK  = 3'd0;
  localparam logic [2:0] KIND_START = 3'd1;
  localparam logic [2:0] KIND_STOP  = 3'd2;
  localparam logic [2:0] KIND_WRITE = 3'd3;
  localparam logic [2:0] KIND_READ  = 3'd4;
  localparam logic [2:0] KIND_WAIT  = 3'd5;

  // configuration register indexes
  localparam logic CFG_PHASE_TICKS = 1'b0;
  localparam logic CFG_ACK_TIMEOUT = 1'b1;

  localparam logic [7:0] PHASE_TICKS_RST = 8'd2;
  localparam logic [7:0] ACK_TIMEOUT_RST = 8'd250;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] data_byte;
    logic       send_ack;
    logic       sda_in;
  } in_word_t;

  typedef struct packed {
    logic       scl_level;
    logic       sda_level;
    logic       sda_driving;
    logic       busy_res;
    logic       done_res;
    logic [7:0] rx_byte;
    logic       ack_failed;
  } out_word_t;

  // classified command carried from front to back
  typedef enum logic [2:0] {
    OP_TICK,
    OP_START,
    OP_STOP,
    OP_WRITE,
    OP_READ,
    OP_WAIT,
    OP_NONE
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [7:0] data_byte;
    logic       send_ack;
    logic       sda_in;
  } cmd_t;

  typedef struct packed {
    logic [7:0] phase_ticks;
    logic [7:0] ack_timeout;
  } cfg_t;

endpackage

// ----- rtl/i2cbm_front.sv -----
// i2cbm_front: takes input words, classifies the kind into a command code
// and holds them in a two-entry command queue for the bus engine
// depends on i2cbm_pkg
module i2cbm_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_push,
  output logic                in_full,
  input  i2cbm_pkg::in_word_t in_word,
  output logic                cmd_valid,
  input  logic                cmd_pop,
  output i2cbm_pkg::cmd_t     cmd_word
);
  import i2cbm_pkg::*;

  cmd_t       q_r [QUEUE_DEPTH];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push, pop;
  cmd_t       cls;

  always_comb begin
    cls.data_byte = in_word.data_byte;
    cls.send_ack  = in_word.send_ack;
    cls.sda_in    = in_word.sda_in;
    unique case (in_word.kind)
      KIND_TICK:  cls.op = OP_TICK;
      KIND_START: cls.op = OP_START;
      KIND_STOP:  cls.op = OP_STOP;
      KIND_WRITE: cls.op = OP_WRITE;
      KIND_READ:  cls.op = OP_READ;
      KIND_WAIT:  cls.op = OP_WAIT;
      default:    cls.op = OP_NONE;
    endcase
  end

  assign in_full   = (cnt_r == 2'(QUEUE_DEPTH));
  assign cmd_valid = (cnt_r != 2'd0);
  assign cmd_word  = q_r[rd_ptr_r];
  assign push      = in_push && !in_full;
  assign pop       = cmd_pop && cmd_valid;

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= cls;
    end
  end

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= 2'(QUEUE_DEPTH))
    else $error("command queue count out of range");

  a_ptr_track: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'(QUEUE_DEPTH) || cnt_r == 2'd0) |-> (wr_ptr_r == rd_ptr_r))
    else $error("command queue pointers disagree with count");

  a_pop_only: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && !push) |=> (cnt_r == $past(cnt_r) - 2'd1))
    else $error("command queue pop did not lower count");
`endif

endmodule

// ----- rtl/i2cbm_back.sv -----
// i2cbm_back: bus engine that steps the i2c phase machine one command a cycle
// while the result queue has room, and a two-entry result queue toward the receiver
// depends on i2cbm_pkg
module i2cbm_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  i2cbm_pkg::cfg_t      cfg,
  input  logic                 cmd_valid,
  output logic                 cmd_pop,
  input  i2cbm_pkg::cmd_t      cmd_word,
  output logic                 out_empty,
  input  logic                 out_pop,
  output i2cbm_pkg::out_word_t out_word
);
  import i2cbm_pkg::*;

  typedef enum logic [3:0] {
    PH_IDLE, PH_S1, PH_S2, PH_S3, PH_P1, PH_P2, PH_P3,
    PH_W_LO, PH_W_HI, PH_R_LO, PH_R_HI, PH_A_LO, PH_A_HI,
    PH_K1, PH_K2, PH_KPOLL
  } phase_t;

  phase_t     state_r, state_nxt;
  logic [3:0] bit_cnt_r, bit_cnt_nxt;
  logic [7:0] shift_r, shift_nxt;
  logic [7:0] tick_r, tick_nxt;
  logic [7:0] wait_r, wait_nxt;
  logic       ack_choice_r, ack_choice_nxt;
  logic       scl_r, scl_nxt;
  logic       sda_r, sda_nxt;
  logic       sda_dir_r, sda_dir_nxt;
  logic       fail_r, fail_nxt;
  logic [7:0] rx_r, rx_nxt;

  logic       fire;
  logic       done;
  logic       go_en;
  phase_t     go_st;
  logic [7:0] len;
  logic [7:0] tick_inc;
  logic [3:0] bc_inc;
  out_word_t  res;

  out_word_t  rq_r [QUEUE_DEPTH];
  logic       rq_wr_r, rq_rd_r;
  logic [1:0] rq_cnt_r;
  logic       rq_full, rq_pop;

  assign rq_full   = (rq_cnt_r == 2'(QUEUE_DEPTH));
  assign out_empty = (rq_cnt_r == 2'd0);
  assign out_word  = rq_r[rq_rd_r];
  assign rq_pop    = out_pop && !out_empty;
  assign fire      = cmd_valid && !rq_full;
  assign cmd_pop   = fire;

  assign len      = (cfg.phase_ticks == 8'd0) ? 8'd1 : cfg.phase_ticks;
  assign tick_inc = tick_r + 8'd1;
  assign bc_inc   = bit_cnt_r + 4'd1;

  always_comb begin
    state_nxt      = state_r;
    bit_cnt_nxt    = bit_cnt_r;
    shift_nxt      = shift_r;
    tick_nxt       = tick_r;
    wait_nxt       = wait_r;
    ack_choice_nxt = ack_choice_r;
    scl_nxt        = scl_r;
    sda_nxt        = sda_r;
    sda_dir_nxt    = sda_dir_r;
    fail_nxt       = fail_r;
    rx_nxt         = rx_r;
    done           = 1'b0;
    go_en          = 1'b0;
    go_st          = PH_IDLE;

    if (fire) begin
      if (cmd_word.op == OP_TICK) begin
        if (state_r == PH_KPOLL) begin
          if (!cmd_word.sda_in) begin
            scl_nxt  = 1'b0;
            fail_nxt = 1'b0;
            go_en    = 1'b1;
            go_st    = PH_IDLE;
            done     = 1'b1;
          end else if (wait_r >= cfg.ack_timeout) begin
            // timed out: run a stop sequence
            fail_nxt = 1'b1;
            go_en    = 1'b1;
            go_st    = PH_P1;
          end else begin
            wait_nxt = wait_r + 8'd1;
          end
        end else if (state_r != PH_IDLE) begin
          tick_nxt = tick_inc;
          if (tick_inc >= len) begin
            go_en = 1'b1;
            unique case (state_r)
              PH_S1:   go_st = PH_S2;
              PH_S2:   go_st = PH_S3;
              PH_P1:   go_st = PH_P2;
              PH_P2:   go_st = PH_P3;
              PH_W_LO: go_st = PH_W_HI;
              PH_W_HI: begin
                shift_nxt   = {shift_r[6:0], 1'b0};
                bit_cnt_nxt = bc_inc;
                if (bc_inc >= 4'(BYTE_BITS)) begin
                  scl_nxt = 1'b0;
                  go_st   = PH_IDLE;
                  done    = 1'b1;
                end else begin
                  go_st = PH_W_LO;
                end
              end
              PH_R_LO: go_st = PH_R_HI;
              PH_R_HI: begin
                // sample on the last tick of the high phase
                shift_nxt   = {shift_r[6:0], cmd_word.sda_in};
                bit_cnt_nxt = bc_inc;
                if (bc_inc >= 4'(BYTE_BITS)) begin
                  rx_nxt = {shift_r[6:0], cmd_word.sda_in};
                  go_st  = PH_A_LO;
                end else begin
                  go_st = PH_R_LO;
                end
              end
              PH_A_LO: go_st = PH_A_HI;
              PH_K1:   go_st = PH_K2;
              PH_K2:   go_st = PH_KPOLL;
              PH_S3, PH_A_HI: begin
                scl_nxt = 1'b0;
                go_st   = PH_IDLE;
                done    = 1'b1;
              end
              PH_P3: begin
                go_st = PH_IDLE;
                done  = 1'b1;
              end
              default: go_st = PH_IDLE;
            endcase
          end
        end
      end else if (cmd_word.op != OP_NONE && state_r == PH_IDLE) begin
        bit_cnt_nxt = 4'd0;
        go_en       = 1'b1;
        unique case (cmd_word.op)
          OP_START: go_st = PH_S1;
          OP_STOP:  go_st = PH_P1;
          OP_WRITE: begin
            shift_nxt = cmd_word.data_byte;
            go_st     = PH_W_LO;
          end
          OP_READ: begin
            shift_nxt      = 8'd0;
            ack_choice_nxt = cmd_word.send_ack;
            go_st          = PH_R_LO;
          end
          default: begin
            fail_nxt = 1'b0;
            go_st    = PH_K1;
          end
        endcase
      end
    end

    // levels set on entry to a phase
    if (go_en) begin
      state_nxt = go_st;
      tick_nxt  = 8'd0;
      unique case (go_st)
        PH_S1: begin
          sda_dir_nxt = 1'b1;
          sda_nxt     = 1'b1;
          scl_nxt     = 1'b1;
        end
        PH_S2: sda_nxt = 1'b0;
        PH_S3: scl_nxt = 1'b0;
        PH_P1: begin
          sda_dir_nxt = 1'b1;
          scl_nxt     = 1'b0;
          sda_nxt     = 1'b0;
        end
        PH_P2: scl_nxt = 1'b1;
        PH_P3: sda_nxt = 1'b1;
        PH_W_LO: begin
          sda_dir_nxt = 1'b1;
          scl_nxt     = 1'b0;
          sda_nxt     = shift_nxt[7];
        end
        PH_W_HI: scl_nxt = 1'b1;
        PH_R_LO: begin
          sda_dir_nxt = 1'b0;
          sda_nxt     = 1'b1;
          scl_nxt     = 1'b0;
        end
        PH_R_HI: scl_nxt = 1'b1;
        PH_A_LO: begin
          scl_nxt     = 1'b0;
          sda_dir_nxt = 1'b1;
          sda_nxt     = ~ack_choice_nxt;
        end
        PH_A_HI: scl_nxt = 1'b1;
        PH_K1: begin
          sda_dir_nxt = 1'b0;
          sda_nxt     = 1'b1;
        end
        PH_K2:    scl_nxt = 1'b1;
        PH_KPOLL: wait_nxt = 8'd0;
        default: ;
      endcase
    end

    res.scl_level   = scl_nxt;
    res.sda_level   = sda_dir_nxt ? sda_nxt : 1'b1;
    res.sda_driving = sda_dir_nxt;
    res.busy_res    = (state_nxt != PH_IDLE);
    res.done_res    = done;
    res.rx_byte     = rx_nxt;
    res.ack_failed  = fail_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= PH_IDLE;
      bit_cnt_r    <= 4'd0;
      shift_r      <= 8'd0;
      tick_r       <= 8'd0;
      wait_r       <= 8'd0;
      ack_choice_r <= 1'b0;
      scl_r        <= 1'b1;
      sda_r        <= 1'b1;
      sda_dir_r    <= 1'b1;
      fail_r       <= 1'b0;
      rx_r         <= 8'd0;
      rq_wr_r      <= 1'b0;
      rq_rd_r      <= 1'b0;
      rq_cnt_r     <= 2'd0;
    end else begin
      state_r      <= state_nxt;
      bit_cnt_r    <= bit_cnt_nxt;
      shift_r      <= shift_nxt;
      tick_r       <= tick_nxt;
      wait_r       <= wait_nxt;
      ack_choice_r <= ack_choice_nxt;
      scl_r        <= scl_nxt;
      sda_r        <= sda_nxt;
      sda_dir_r    <= sda_dir_nxt;
      fail_r       <= fail_nxt;
      rx_r         <= rx_nxt;
      rq_wr_r      <= fire ? ~rq_wr_r : rq_wr_r;
      rq_rd_r      <= rq_pop ? ~rq_rd_r : rq_rd_r;
      rq_cnt_r     <= rq_cnt_r + 2'(fire) - 2'(rq_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      rq_r[rq_wr_r] <= res;
    end
  end

`ifndef SYNTHESIS
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && done) |=> (state_r == PH_IDLE))
    else $error("command finished but engine not idle");

  a_released_high: assert property (@(posedge clk) disable iff (!rst_n)
    !sda_dir_r |-> sda_r)
    else $error("sda released while held low");

  a_bit_bound: assert property (@(posedge clk) disable iff (!rst_n)
    bit_cnt_r <= 4'(BYTE_BITS))
    else $error("bit count past byte width");

  a_result_count: assert property (@(posedge clk) disable iff (!rst_n)
    rq_cnt_r <= 2'(QUEUE_DEPTH))
    else $error("result queue count out of range");
`endif

endmodule

// ----- rtl/i2c_bit_master_top.sv -----
// i2c_bit_master_top: i2c bit master with configuration registers
// joins the command front end and the bus engine back end
// depends on i2cbm_pkg, i2cbm_front, i2cbm_back
//
// usage: push input words (tick, start, stop, write byte, read byte, wait ack)
// while in_full is low; every accepted word yields exactly one result word with
// the bus levels, busy, done, received byte and ack-failed flag after that word.
// commands are taken only while the engine is idle; tick words step the bus.
// a word's result is registered into the result queue before out_word shows it.
// throughput: one word per cycle while the result queue has room. a two-entry
// command queue and a two-entry result queue sit between the sides; when the
// receiver stops popping, the result queue fills, the engine holds, then the
// command queue fills and in_full rises.
// configuration: cfg_we with cfg_index 0 (phase ticks) or 1 (ack timeout);
// write these only while the block is idle; the block does not enforce this.
// reset: synchronous active-low rst_n empties both queues, idles the engine
// with scl and sda high, and loads phase ticks 2 and ack timeout 250.
module i2c_bit_master_top (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_push,
  output logic                 in_full,
  input  i2cbm_pkg::in_word_t  in_word,
  output logic                 out_empty,
  input  logic                 out_pop,
  output i2cbm_pkg::out_word_t out_word,
  input  logic                 cfg_we,
  input  logic                 cfg_index,
  input  logic [7:0]           cfg_wdata
);
  import i2cbm_pkg::*;

  cfg_t cfg_r;
  logic cmd_valid;
  logic cmd_pop;
  cmd_t cmd_word;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.phase_ticks <= PHASE_TICKS_RST;
      cfg_r.ack_timeout <= ACK_TIMEOUT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_PHASE_TICKS: cfg_r.phase_ticks <= cfg_wdata;
        CFG_ACK_TIMEOUT: cfg_r.ack_timeout <= cfg_wdata;
        default: ;
      endcase
    end
  end

  i2cbm_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_full   (in_full),
    .in_word   (in_word),
    .cmd_valid (cmd_valid),
    .cmd_pop   (cmd_pop),
    .cmd_word  (cmd_word)
  );

  i2cbm_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .cmd_valid (cmd_valid),
    .cmd_pop   (cmd_pop),
    .cmd_word  (cmd_word),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_word  (out_word)
  );

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 1ps
// tb: self-checking bench for i2c_bit_master_top, bus behavior predicted in-line
// depends on i2cbm_pkg and i2c_bit_master_top
module tb;
  import i2cbm_pkg::*;

  localparam logic [2:0] KIND_BAD6 = 3'd6;
  localparam logic [2:0] KIND_BAD7 = 3'd7;
  localparam int STALL_LIMIT = 2000;

  typedef enum logic [3:0] {
    B_IDLE, B_S1, B_S2, B_S3, B_P1, B_P2, B_P3, B_W_LO, B_W_HI,
    B_R_LO, B_R_HI, B_A_LO, B_A_HI, B_K1, B_K2, B_KPOLL
  } bus_st_t;

  typedef struct packed {
    in_word_t  w;
    logic [7:0] reps;
    logic       typed;
    out_word_t  want;
  } dir_row_t;

  logic       clk;
  logic       rst_n = 1'b0;
  logic       in_push = 1'b0;
  logic       in_full;
  in_word_t   in_word = '0;
  logic       out_empty;
  logic       out_pop = 1'b0;
  out_word_t  out_word;
  logic       cfg_we = 1'b0;
  logic       cfg_index = 1'b0;
  logic [7:0] cfg_wdata = 8'd0;

  i2c_bit_master_top dut (
    .clk(clk), .rst_n(rst_n),
    .in_push(in_push), .in_full(in_full), .in_word(in_word),
    .out_empty(out_empty), .out_pop(out_pop), .out_word(out_word),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // bus model state
  bus_st_t    bst;
  logic [3:0] nbits;
  logic [7:0] shreg, tcnt, pcnt, rxq;
  logic       ackc, scl_q, sda_q, drv_q, fail_q;
  logic [7:0] m_phase, m_timeout;

  out_word_t  words_due[$];
  dir_row_t   dir_rows[$];
  int         n_bad = 0, n_sent = 0, n_live = 0, n_got = 0, n_settings = 0;
  int         burst_left = 0;
  int         stall_cyc = 0;
  logic [7:0] pop_cyc = 8'd0;
  logic [1:0] pop_mode = 2'd0;
  logic [15:0] pop_mask = 16'hffff;

  function automatic void model_reset();
    m_phase = PHASE_TICKS_RST;
    m_timeout = ACK_TIMEOUT_RST;
    bst = B_IDLE;
    nbits = 4'd0;
    shreg = 8'd0;
    tcnt = 8'd0;
    pcnt = 8'd0;
    rxq = 8'd0;
    ackc = 1'b0;
    scl_q = 1'b1;
    sda_q = 1'b1;
    drv_q = 1'b1;
    fail_q = 1'b0;
  endfunction

  function automatic void bus_go(bus_st_t s);
    bst = s;
    tcnt = 8'd0;
    case (s)
      B_S1: begin drv_q = 1'b1; sda_q = 1'b1; scl_q = 1'b1; end
      B_S2: sda_q = 1'b0;
      B_S3: scl_q = 1'b0;
      B_P1: begin drv_q = 1'b1; scl_q = 1'b0; sda_q = 1'b0; end
      B_P2: scl_q = 1'b1;
      B_P3: sda_q = 1'b1;
      B_W_LO: begin drv_q = 1'b1; scl_q = 1'b0; sda_q = shreg[7]; end
      B_W_HI: scl_q = 1'b1;
      B_R_LO: begin drv_q = 1'b0; sda_q = 1'b1; scl_q = 1'b0; end
      B_R_HI: scl_q = 1'b1;
      B_A_LO: begin scl_q = 1'b0; drv_q = 1'b1; sda_q = ~ackc; end
      B_A_HI: scl_q = 1'b1;
      B_K1: begin drv_q = 1'b0; sda_q = 1'b1; end
      B_K2: scl_q = 1'b1;
      B_KPOLL: pcnt = 8'd0;
      default: bst = B_IDLE;
    endcase
  endfunction

  // one bus tick; returns 1 when the running command completes
  function automatic logic bus_tick(logic sda);
    logic [7:0] len;
    if (bst == B_KPOLL) begin
      if (!sda) begin
        scl_q = 1'b0;
        fail_q = 1'b0;
        bus_go(B_IDLE);
        return 1'b1;
      end
      if (pcnt >= m_timeout) begin
        fail_q = 1'b1;
        bus_go(B_P1);
      end else begin
        pcnt = pcnt + 8'd1;
      end
      return 1'b0;
    end
    len = (m_phase != 8'd0) ? m_phase : 8'd1;
    tcnt = tcnt + 8'd1;
    if (tcnt < len) return 1'b0;
    case (bst)
      B_S1: bus_go(B_S2);
      B_S2: bus_go(B_S3);
      B_P1: bus_go(B_P2);
      B_P2: bus_go(B_P3);
      B_W_LO: bus_go(B_W_HI);
      B_W_HI: begin
        shreg = shreg << 1;
        nbits = nbits + 4'd1;
        if (nbits >= BYTE_BITS) begin
          scl_q = 1'b0;
          bus_go(B_IDLE);
          return 1'b1;
        end
        bus_go(B_W_LO);
      end
      B_R_LO: bus_go(B_R_HI);
      B_R_HI: begin
        shreg = {shreg[6:0], sda};
        nbits = nbits + 4'd1;
        if (nbits >= BYTE_BITS) begin
          rxq = shreg;
          bus_go(B_A_LO);
        end else begin
          bus_go(B_R_LO);
        end
      end
      B_A_LO: bus_go(B_A_HI);
      B_K1: bus_go(B_K2);
      B_K2: bus_go(B_KPOLL);
      B_S3, B_A_HI: begin
        scl_q = 1'b0;
        bus_go(B_IDLE);
        return 1'b1;
      end
      B_P3: begin
        bus_go(B_IDLE);
        return 1'b1;
      end
      default: bus_go(B_IDLE);
    endcase
    return 1'b0;
  endfunction

  function automatic out_word_t bus_apply(in_word_t w);
    out_word_t o;
    logic fin;
    fin = 1'b0;
    if (w.kind == KIND_TICK) begin
      if (bst != B_IDLE) fin = bus_tick(w.sda_in);
    end else if (w.kind <= KIND_WAIT && bst == B_IDLE) begin
      nbits = 4'd0;
      case (w.kind)
        KIND_START: bus_go(B_S1);
        KIND_STOP: bus_go(B_P1);
        KIND_WRITE: begin
          shreg = w.data_byte;
          bus_go(B_W_LO);
        end
        KIND_READ: begin
          shreg = 8'd0;
          ackc = w.send_ack;
          bus_go(B_R_LO);
        end
        default: begin
          fail_q = 1'b0;
          bus_go(B_K1);
        end
      endcase
    end
    o.scl_level = scl_q;
    o.sda_level = drv_q ? sda_q : 1'b1;
    o.sda_driving = drv_q;
    o.busy_res = (bst != B_IDLE);
    o.done_res = fin;
    o.rx_byte = rxq;
    o.ack_failed = fail_q;
    return o;
  endfunction

  function automatic out_word_t mk_out(logic scl, logic sda, logic drv, logic busy);
    out_word_t o;
    o = '0;
    o.scl_level = scl;
    o.sda_level = sda;
    o.sda_driving = drv;
    o.busy_res = busy;
    return o;
  endfunction

  function automatic dir_row_t mk_row(logic [2:0] kind, logic [7:0] data, logic ack,
                                      logic sda, logic [7:0] reps, logic typed,
                                      out_word_t want);
    dir_row_t r;
    r.w.kind = kind;
    r.w.data_byte = data;
    r.w.send_ack = ack;
    r.w.sda_in = sda;
    r.reps = reps;
    r.typed = typed;
    r.want = want;
    return r;
  endfunction

  function automatic in_word_t rand_word();
    in_word_t w;
    w.kind = 3'($urandom_range(0, 7));
    w.data_byte = 8'($urandom);
    w.send_ack = 1'($urandom_range(0, 1));
    w.sda_in = 1'($urandom_range(0, 1));
    return w;
  endfunction

  task automatic send_word(input in_word_t w, input logic typed = 1'b0,
                           input out_word_t want = '0);
    int gap;
    out_word_t pred;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        in_push <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 48);
    end
    burst_left--;
    in_word <= w;
    in_push <= 1'b1;
    do @(posedge clk); while (in_full);
    n_sent++;
    if (w.kind == KIND_TICK ? (bst != B_IDLE) : (w.kind <= KIND_WAIT && bst == B_IDLE))
      n_live++;
    pred = bus_apply(w);
    words_due.push_back(typed ? want : pred);
  endtask

  task automatic hold_off();
    in_push <= 1'b0;
    while (words_due.size() != 0) @(posedge clk);
    burst_left = 0;
  endtask

  task automatic set_regs(input logic [7:0] pt, input logic [7:0] to);
    hold_off();
    cfg_we <= 1'b1;
    cfg_index <= CFG_PHASE_TICKS;
    cfg_wdata <= pt;
    @(posedge clk);
    cfg_index <= CFG_ACK_TIMEOUT;
    cfg_wdata <= to;
    @(posedge clk);
    cfg_we <= 1'b0;
    m_phase = pt;
    m_timeout = to;
    n_settings++;
  endtask

  // finish whatever command is running, acknowledging any wait
  task automatic settle_bus();
    in_word_t w;
    w = '0;
    w.kind = KIND_TICK;
    while (bst != B_IDLE) send_word(w);
  endtask

  task automatic run_phase(input logic [7:0] pt, input logic [7:0] to, input int budget);
    int live0, pick, polls, k;
    in_word_t w;
    set_regs(pt, to);
    live0 = n_live;
    while (n_live - live0 < budget) begin
      pick = $urandom_range(0, 99);
      if (pick < 3) hold_off();
      if (pick < 80) begin
        w = rand_word();
        w.kind = 3'($urandom_range(1, 5));
        polls = 0;
        k = $urandom_range(0, 1) ? $urandom_range(0, 3) : $urandom_range(0, int'(to) + 1);
        send_word(w);
        while (bst != B_IDLE) begin
          if ($urandom_range(0, 24) == 0) begin
            // command while busy, should be dropped
            w = rand_word();
            w.kind = 3'($urandom_range(1, 7));
            send_word(w);
          end
          w = rand_word();
          w.kind = KIND_TICK;
          if (bst == B_KPOLL) begin
            w.sda_in = (polls >= k) ? 1'b0 : 1'b1;
            polls++;
          end
          send_word(w);
        end
      end else begin
        w = rand_word();
        if ($urandom_range(0, 1)) w.kind = KIND_TICK;
        send_word(w);
      end
    end
    settle_bus();
  endtask

  // receiver: pop pattern and mask are redrawn each time pop_cyc[5:0] returns to zero
  always @(posedge clk) begin
    if (!rst_n) begin
      out_pop <= 1'b0;
    end else begin
      pop_cyc <= pop_cyc + 8'd1;
      if (pop_cyc[5:0] == 6'd0) begin
        pop_mode <= 2'($urandom_range(0, 3));
        pop_mask <= 16'($urandom) | 16'd1;
      end
      case (pop_mode)
        2'd0: out_pop <= 1'b1;
        2'd1: out_pop <= 1'($urandom_range(0, 1));
        2'd2: out_pop <= pop_mask[pop_cyc[3:0]];
        default: out_pop <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  always @(posedge clk) begin
    out_word_t want;
    if (rst_n && out_pop && !out_empty) begin
      n_got++;
      if (words_due.size() == 0) begin
        n_bad++;
        if (n_bad <= 10) $display("unexpected result word %h", out_word);
      end else begin
        want = words_due.pop_front();
        if (out_word.scl_level !== want.scl_level || out_word.sda_level !== want.sda_level ||
            out_word.sda_driving !== want.sda_driving || out_word.busy_res !== want.busy_res ||
            out_word.done_res !== want.done_res || out_word.rx_byte !== want.rx_byte ||
            out_word.ack_failed !== want.ack_failed) begin
          n_bad++;
          if (n_bad <= 10)
            $display("word %0d: exp scl %b sda %b drv %b busy %b done %b rx %h fail %b",
                     n_got, want.scl_level, want.sda_level, want.sda_driving, want.busy_res,
                     want.done_res, want.rx_byte, want.ack_failed);
          if (n_bad <= 10)
            $display("        got scl %b sda %b drv %b busy %b done %b rx %h fail %b",
                     out_word.scl_level, out_word.sda_level, out_word.sda_driving,
                     out_word.busy_res, out_word.done_res, out_word.rx_byte,
                     out_word.ack_failed);
        end
      end
    end
  end

  // watchdog: nothing moving on either side for too long
  always @(posedge clk) begin
    if ((in_push && !in_full) || (out_pop && !out_empty)) begin
      stall_cyc <= 0;
    end else if (stall_cyc >= STALL_LIMIT) begin
      $display("i2c_bit_master_top: mismatch");
      $finish;
    end else begin
      stall_cyc <= stall_cyc + 1;
    end
  end

  initial begin
    out_word_t idle_w;
    model_reset();
    idle_w = mk_out(1'b1, 1'b1, 1'b1, 1'b0);
    // zero phase length and zero timeout during the directed words
    dir_rows.push_back(mk_row(KIND_TICK, 8'h00, 1'b0, 1'b0, 8'd1, 1'b1, idle_w));
    dir_rows.push_back(mk_row(KIND_BAD6, 8'h00, 1'b0, 1'b0, 8'd1, 1'b1, idle_w));
    dir_rows.push_back(mk_row(KIND_BAD7, 8'hff, 1'b1, 1'b1, 8'd1, 1'b1, idle_w));
    dir_rows.push_back(mk_row(KIND_TICK, 8'hff, 1'b1, 1'b1, 8'd1, 1'b1, idle_w));
    dir_rows.push_back(mk_row(KIND_START, 8'h00, 1'b0, 1'b0, 8'd1, 1'b1,
                              mk_out(1'b1, 1'b1, 1'b1, 1'b1)));
    dir_rows.push_back(mk_row(KIND_WRITE, 8'hff, 1'b1, 1'b1, 8'd1, 1'b1,
                              mk_out(1'b1, 1'b1, 1'b1, 1'b1)));
    dir_rows.push_back(mk_row(KIND_TICK, 8'h00, 1'b0, 1'b0, 8'd3, 1'b0, '0));
    dir_rows.push_back(mk_row(KIND_STOP, 8'h00, 1'b0, 1'b0, 8'd1, 1'b1,
                              mk_out(1'b0, 1'b0, 1'b1, 1'b1)));
    dir_rows.push_back(mk_row(KIND_TICK, 8'h00, 1'b0, 1'b1, 8'd3, 1'b0, '0));
    dir_rows.push_back(mk_row(KIND_WAIT, 8'h00, 1'b0, 1'b0, 8'd1, 1'b1,
                              mk_out(1'b1, 1'b1, 1'b0, 1'b1)));
    // sda never low: times out and runs a stop
    dir_rows.push_back(mk_row(KIND_TICK, 8'h00, 1'b0, 1'b1, 8'd6, 1'b0, '0));
    // second wait clears the failure flag at its start
    dir_rows.push_back(mk_row(KIND_WAIT, 8'h00, 1'b0, 1'b0, 8'd1, 1'b1,
                              mk_out(1'b1, 1'b1, 1'b0, 1'b1)));
    dir_rows.push_back(mk_row(KIND_TICK, 8'h00, 1'b0, 1'b0, 8'd3, 1'b0, '0));
    dir_rows.push_back(mk_row(KIND_READ, 8'h00, 1'b1, 1'b0, 8'd1, 1'b1,
                              mk_out(1'b0, 1'b1, 1'b0, 1'b1)));

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    set_regs(8'd0, 8'd0);
    foreach (dir_rows[i])
      repeat (dir_rows[i].reps) send_word(dir_rows[i].w, dir_rows[i].typed, dir_rows[i].want);
    settle_bus();

    run_phase(PHASE_TICKS_RST, ACK_TIMEOUT_RST, 400);
    run_phase(8'd1, 8'd1, 400);
    run_phase(8'd4, 8'd3, 300);
    run_phase(8'd9, 8'd1, 100);
    run_phase(8'd1, 8'd255, 300);

    hold_off();
    repeat (4) @(posedge clk);
    $display("sent %0d words (%0d stepping the bus) under %0d register settings",
             n_sent, n_live, n_settings);
    $display("checked %0d result words, %0d bad", n_got, n_bad);
    if (n_bad == 0 && words_due.size() == 0) begin
      $display("i2c_bit_master_top: match");
    end else begin
      $display("i2c_bit_master_top: mismatch");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/i2cbm_pkg.sv
rtl/i2cbm_front.sv
rtl/i2cbm_back.sv
rtl/i2c_bit_master_top.sv
tb/tb.sv
